@@ rtl/core/u8u16_pkg.sv @@
// ----------------------------------------------------------------------------
// u8u16_pkg
// Types and constants shared by the UTF-8 to UTF-16 decoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_of_run;
  } out_item_t;

  localparam logic [1:0] NEED_NONE  = 2'd0;
  localparam logic [1:0] NEED_ONE   = 2'd1;
  localparam logic [1:0] NEED_TWO   = 2'd2;
  localparam logic [1:0] NEED_THREE = 2'd3;

  localparam logic [7:0]  LEAD2_MASK   = 8'he0;
  localparam logic [7:0]  LEAD2_CODE   = 8'hc0;
  localparam logic [7:0]  LEAD3_MASK   = 8'hf0;
  localparam logic [7:0]  LEAD3_CODE   = 8'he0;
  localparam logic [20:0] PLANE1_BASE  = 21'h10000;
  localparam logic [15:0] SURR_HIGH    = 16'hd800;
  localparam logic [15:0] SURR_LOW     = 16'hdc00;

endpackage

@@ rtl/core/utf8_to_utf16_decoder.sv @@
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder
// Stream decoder from UTF-8 bytes to UTF-16 code units.
// ----------------------------------------------------------------------------
// Usage: the text channel carries one UTF-8 byte per word with a flag on the
// final byte of the text; the unit channel carries UTF-16 code units, with a
// flag on the last unit caused by one byte. Both channels use valid/stall.
// An accepted byte sits in an input register; the decode of that byte and the
// held sequence state runs in one pass into a result register of up to three
// units. A byte that completes a sequence has its first unit on the unit
// channel once it has moved from the input register to the result register.
// One byte is taken per cycle while each byte gives at most one unit and
// unit_stall is low; a byte that gives two or three units holds the input
// side while the result register drains one unit per cycle unless unit_stall
// is high. While the unit receiver stalls, one further byte is still taken
// into the input register before text_stall rises. Reset clears the pending
// sequence and both registers; no unit is lost or repeated under stalls.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 text_valid,
  output logic                 text_stall,
  input  u8u16_pkg::in_item_t  text_item,
  output logic                 unit_valid,
  input  logic                 unit_stall,
  output u8u16_pkg::out_item_t unit_item
);

  u8u16_pkg::in_item_t inq;
  logic                inq_valid;

  logic [7:0] lead_held;
  logic [1:0] bytes_needed;
  logic [1:0] bytes_held;
  logic [7:0] follow_store [2];

  logic [7:0] lead_held_next;
  logic [1:0] bytes_needed_next;
  logic [1:0] bytes_held_next;
  logic       follow_wr;

  logic [1:0]  res_cnt;
  logic [15:0] res_unit [3];

  logic [1:0]  dec_cnt;
  logic [15:0] dec_unit [3];

  logic        out_take;
  logic        res_free;
  logic        move;
  logic        in_take;

  logic [7:0]  b;
  logic [2:0]  held_plus;
  logic [20:0] wide_ch;
  logic [19:0] wide_off;

  assign out_take   = (res_cnt != 2'd0) && !unit_stall;
  assign res_free   = (res_cnt == 2'd0) || ((res_cnt == 2'd1) && out_take);
  assign move       = inq_valid && res_free;
  assign text_stall = inq_valid && !res_free;
  assign in_take    = text_valid && !text_stall;

  assign unit_valid            = (res_cnt != 2'd0);
  assign unit_item.code_unit   = res_unit[0];
  assign unit_item.last_of_run = (res_cnt == 2'd1);

  assign b         = inq.in_byte;
  assign held_plus = {1'b0, bytes_held} + 3'd1;
  assign wide_ch   = {lead_held[2:0], follow_store[0][5:0], follow_store[1][5:0], b[5:0]};
  assign wide_off  = 20'(wide_ch - u8u16_pkg::PLANE1_BASE);

  always_comb begin
    lead_held_next    = lead_held;
    bytes_needed_next = bytes_needed;
    bytes_held_next   = bytes_held;
    follow_wr         = 1'b0;
    dec_cnt           = 2'd0;
    dec_unit[0]       = {8'd0, b};
    dec_unit[1]       = {8'd0, b};
    dec_unit[2]       = {8'd0, b};
    if (bytes_needed == u8u16_pkg::NEED_NONE) begin
      if (!b[7] || inq.end_of_text) begin
        dec_cnt = 2'd1;
      end else begin
        lead_held_next  = b;
        bytes_held_next = 2'd0;
        if ((b & u8u16_pkg::LEAD2_MASK) == u8u16_pkg::LEAD2_CODE) begin
          bytes_needed_next = u8u16_pkg::NEED_ONE;
        end else if ((b & u8u16_pkg::LEAD3_MASK) == u8u16_pkg::LEAD3_CODE) begin
          bytes_needed_next = u8u16_pkg::NEED_TWO;
        end else begin
          bytes_needed_next = u8u16_pkg::NEED_THREE;
        end
      end
    end else if ((held_plus >= {1'b0, bytes_needed}) || inq.end_of_text) begin
      bytes_needed_next = u8u16_pkg::NEED_NONE;
      bytes_held_next   = 2'd0;
      if (held_plus == {1'b0, bytes_needed}) begin
        case (bytes_needed)
          u8u16_pkg::NEED_ONE: begin
            dec_cnt     = 2'd1;
            dec_unit[0] = {5'd0, lead_held[4:0], b[5:0]};
          end
          u8u16_pkg::NEED_TWO: begin
            dec_cnt     = 2'd1;
            dec_unit[0] = {lead_held[3:0], follow_store[0][5:0], b[5:0]};
          end
          u8u16_pkg::NEED_THREE: begin
            if (wide_ch[20:16] != 5'd0) begin
              dec_cnt     = 2'd2;
              dec_unit[0] = u8u16_pkg::SURR_HIGH + {6'd0, wide_off[19:10]};
              dec_unit[1] = u8u16_pkg::SURR_LOW + {6'd0, wide_off[9:0]};
            end else begin
              dec_cnt     = 2'd1;
              dec_unit[0] = wide_ch[15:0];
            end
          end
          default: begin
            dec_cnt = 2'd1;
          end
        endcase
      end else begin
        dec_unit[0] = {8'd0, lead_held};
        if (bytes_held == 2'd0) begin
          dec_cnt     = 2'd2;
          dec_unit[1] = {8'd0, b};
        end else if ((follow_store[0] & u8u16_pkg::LEAD2_MASK) == u8u16_pkg::LEAD2_CODE) begin
          dec_cnt     = 2'd2;
          dec_unit[1] = {5'd0, follow_store[0][4:0], b[5:0]};
        end else begin
          dec_cnt     = 2'd3;
          dec_unit[1] = {8'd0, follow_store[0]};
          dec_unit[2] = {8'd0, b};
        end
      end
    end else begin
      follow_wr       = 1'b1;
      bytes_held_next = 2'(held_plus);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid    <= 1'b0;
      res_cnt      <= 2'd0;
      lead_held    <= 8'd0;
      bytes_needed <= u8u16_pkg::NEED_NONE;
      bytes_held   <= 2'd0;
    end else begin
      if (in_take) begin
        inq_valid <= 1'b1;
      end else if (move) begin
        inq_valid <= 1'b0;
      end
      if (move) begin
        res_cnt      <= dec_cnt;
        lead_held    <= lead_held_next;
        bytes_needed <= bytes_needed_next;
        bytes_held   <= bytes_held_next;
      end else if (out_take) begin
        res_cnt <= res_cnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      inq <= text_item;
    end
    if (move && follow_wr) begin
      follow_store[bytes_held[0]] <= b;
    end
    if (move) begin
      res_unit[0] <= dec_unit[0];
      res_unit[1] <= dec_unit[1];
      res_unit[2] <= dec_unit[2];
    end else if (out_take) begin
      res_unit[0] <= res_unit[1];
      res_unit[1] <= res_unit[2];
    end
  end

  a_held_below_needed: assert property (@(posedge clk) disable iff (rst)
    (bytes_needed != u8u16_pkg::NEED_NONE) |-> (bytes_held < bytes_needed))
    else $error("held byte count reached the needed count");

  a_idle_no_held: assert property (@(posedge clk) disable iff (rst)
    (bytes_needed == u8u16_pkg::NEED_NONE) |-> (bytes_held == 2'd0))
    else $error("held bytes without a pending sequence");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (move && inq.end_of_text) |=> (bytes_needed == u8u16_pkg::NEED_NONE))
    else $error("sequence still pending after the final byte");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    text_stall |-> (inq_valid && (res_cnt != 2'd0)))
    else $error("input stalled with room to move");

  a_inq_kept: assert property (@(posedge clk) disable iff (rst)
    (inq_valid && !move) |=> inq_valid)
    else $error("buffered byte dropped");

endmodule
